// ===== rtl/prq_pkg.sv =====
// shared constants, command codes and control structs of the priority ready queue
`default_nettype none
package prq_pkg;

    localparam int CMD_W   = 3;
    localparam int TASK_W  = 6;
    localparam int PRIO_W  = 6;

    localparam int DEF_PRIORITY_LEVELS = 64;
    localparam int DEF_TASK_SLOTS      = 64;

    localparam logic [CMD_W-1:0] CMD_ADD_POLICY = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_HEAD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD_TAIL   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MOVE_TAIL  = 3'd4;

    typedef struct packed {
        logic capture;
        logic look;
        logic fix;
        logic fetch;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_fix;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== rtl/prq_if.sv =====
// request and result channel interfaces of the priority ready queue
`default_nettype none
interface prq_req_if;
    logic                       valid;
    logic                       ready;
    logic [prq_pkg::CMD_W-1:0]  command;
    logic [prq_pkg::TASK_W-1:0] task_id;
    logic [prq_pkg::PRIO_W-1:0] task_priority;
    logic [prq_pkg::PRIO_W-1:0] active_priority;
    modport source (output valid, command, task_id, task_priority, active_priority,
                    input ready);
    modport sink (input valid, command, task_id, task_priority, active_priority,
                  output ready);
endinterface

interface prq_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       ready_valid;
    logic [prq_pkg::PRIO_W-1:0] top_priority;
    logic [prq_pkg::TASK_W-1:0] next_task;
    logic                       empty_error;
    modport source (output valid, ready_valid, top_priority, next_task, empty_error,
                    input ready);
    modport sink (input valid, ready_valid, top_priority, next_task, empty_error,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/prq_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module prq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/prq_ctrl.sv =====
// sequencing state machine and result handshake of the priority ready queue
`default_nettype none
module prq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire prq_pkg::t_dp_stat i_stat,
    output prq_pkg::t_dp_cmd       o_cmd
);
    import prq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOOK  = 5'b00010,
        S_FIX   = 5'b00100,
        S_FETCH = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign load        = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        o_cmd.look    = (r_state == S_LOOK);
        o_cmd.fix     = (r_state == S_FIX);
        o_cmd.fetch   = (r_state == S_FETCH);
        o_cmd.load    = load;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_LOOK;
            S_LOOK:  n_state = i_stat.need_fix ? S_FIX : S_FETCH;
            S_FIX:   n_state = S_FETCH;
            S_FETCH: n_state = S_DONE;
            S_DONE:  if (load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_fix_after_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIX) |-> $past(r_state == S_LOOK))
        else $error("fix step without preceding look step");
    a_fetch_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |=> (r_state == S_DONE))
        else $error("head fetch not followed by result stage");
    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("result overwritten while still pending");
`endif
endmodule
`default_nettype wire

// ===== rtl/prq_datapath.sv =====
// level bitmap, link memories and list update logic of the priority ready queue
`default_nettype none
module prq_datapath #(
    parameter int PRIORITY_LEVELS = prq_pkg::DEF_PRIORITY_LEVELS,
    parameter int TASK_SLOTS      = prq_pkg::DEF_TASK_SLOTS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire prq_pkg::t_dp_cmd           i_cmd,
    output prq_pkg::t_dp_stat               o_stat,
    input  wire logic [prq_pkg::CMD_W-1:0]  i_command,
    input  wire logic [prq_pkg::TASK_W-1:0] i_task_id,
    input  wire logic [prq_pkg::PRIO_W-1:0] i_task_priority,
    input  wire logic [prq_pkg::PRIO_W-1:0] i_active_priority,
    output logic                            o_ready_valid,
    output logic      [prq_pkg::PRIO_W-1:0] o_top_priority,
    output logic      [prq_pkg::TASK_W-1:0] o_next_task,
    output logic                            o_empty_error
);
    import prq_pkg::*;

    localparam int TW = $clog2(TASK_SLOTS);
    localparam int LW = $clog2(PRIORITY_LEVELS);

    logic [CMD_W-1:0]           r_cmd;
    logic [TW-1:0]              r_t;
    logic [LW-1:0]              r_p;
    logic                       r_policy_tail;
    logic                       r_in_range;
    logic [PRIORITY_LEVELS-1:0] r_bitmap, n_bitmap;
    logic [TASK_SLOTS-1:0]      r_queued, n_queued;
    logic                       r_err, n_err;

    logic [TW-1:0] hd_q, tl_q, nx_q, pv_q;
    logic [LW-1:0] lvl_q;

    logic          hd_we, tl_we, nx_we, pv_we, lvl_we;
    logic [LW-1:0] hd_wa, tl_wa, hd_ra;
    logic [TW-1:0] nx_wa, pv_wa, nx_wd, pv_wd, hd_wd, tl_wd;

    logic          queued, busy, member, is_head, is_tail;
    logic [LW-1:0] best;

    // lowest busy level wins
    always_comb begin
        best = '0;
        for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
            if (r_bitmap[i]) best = LW'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd         <= i_command;
            r_t           <= TW'(i_task_id);
            r_p           <= LW'(i_task_priority);
            r_policy_tail <= (i_task_priority == i_active_priority);
            r_in_range    <= (32'(i_task_id) < TASK_SLOTS)
                             && (32'(i_task_priority) < PRIORITY_LEVELS);
        end
    end

    assign queued  = r_queued[r_t];
    assign busy    = r_bitmap[r_p];
    assign member  = queued && (lvl_q == r_p);
    assign is_head = (r_t == hd_q);
    assign is_tail = (r_t == tl_q);

    always_comb begin
        hd_we = 1'b0; tl_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0; lvl_we = 1'b0;
        hd_wa = r_p;  tl_wa = r_p;  hd_wd = r_t;  tl_wd = r_t;
        nx_wa = r_t;  nx_wd = hd_q; pv_wa = hd_q; pv_wd = r_t;
        n_bitmap = r_bitmap;
        n_queued = r_queued;
        n_err    = r_err;
        o_stat.need_fix = 1'b0;
        if (i_cmd.look) begin
            n_err = 1'b0;
            if (r_in_range) begin
                if ((r_cmd inside {CMD_ADD_POLICY, CMD_ADD_HEAD, CMD_ADD_TAIL}) && !queued) begin
                    n_queued[r_t] = 1'b1;
                    n_bitmap[r_p] = 1'b1;
                    lvl_we        = 1'b1;
                    if (!busy) begin
                        hd_we = 1'b1;
                        tl_we = 1'b1;
                    end else if (r_cmd == CMD_ADD_TAIL
                                 || (r_cmd == CMD_ADD_POLICY && r_policy_tail)) begin
                        pv_we = 1'b1; pv_wa = r_t;  pv_wd = tl_q;
                        nx_we = 1'b1; nx_wa = tl_q; nx_wd = r_t;
                        tl_we = 1'b1;
                    end else begin
                        nx_we = 1'b1; nx_wa = r_t;  nx_wd = hd_q;
                        pv_we = 1'b1; pv_wa = hd_q; pv_wd = r_t;
                        hd_we = 1'b1;
                    end
                end else if (r_cmd == CMD_REMOVE && member) begin
                    n_queued[r_t] = 1'b0;
                    if (is_head && is_tail) begin
                        n_bitmap[r_p] = 1'b0;
                    end else if (is_head) begin
                        hd_we = 1'b1; hd_wd = nx_q;
                    end else if (is_tail) begin
                        tl_we = 1'b1; tl_wd = pv_q;
                    end else begin
                        nx_we = 1'b1; nx_wa = pv_q; nx_wd = nx_q;
                        pv_we = 1'b1; pv_wa = nx_q; pv_wd = pv_q;
                    end
                    n_err = (n_bitmap == '0);
                end else if (r_cmd == CMD_MOVE_TAIL && member && !is_tail) begin
                    // a lone task or the tail itself stays where it is
                    tl_we = 1'b1;
                    if (is_head) begin
                        hd_we = 1'b1; hd_wd = nx_q;
                        pv_we = 1'b1; pv_wa = r_t;  pv_wd = tl_q;
                        nx_we = 1'b1; nx_wa = tl_q; nx_wd = r_t;
                    end else begin
                        nx_we = 1'b1; nx_wa = pv_q; nx_wd = nx_q;
                        pv_we = 1'b1; pv_wa = nx_q; pv_wd = pv_q;
                        o_stat.need_fix = 1'b1;
                    end
                end
            end
        end else if (i_cmd.fix) begin
            // second half of a middle move: append behind the old tail
            pv_we = 1'b1; pv_wa = r_t;  pv_wd = tl_q;
            nx_we = 1'b1; nx_wa = tl_q; nx_wd = r_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bitmap <= '0;
            r_queued <= '0;
            r_err    <= 1'b0;
        end else begin
            r_bitmap <= n_bitmap;
            r_queued <= n_queued;
            r_err    <= n_err;
        end
    end

    assign hd_ra = i_cmd.fetch ? best : LW'(i_task_priority);

    prq_ram #(.WIDTH(TW), .DEPTH(PRIORITY_LEVELS)) u_head (
        .i_clk(i_clk), .i_we(hd_we), .i_waddr(hd_wa), .i_wdata(hd_wd),
        .i_re(i_cmd.capture | i_cmd.fetch), .i_raddr(hd_ra), .o_rdata(hd_q));
    prq_ram #(.WIDTH(TW), .DEPTH(PRIORITY_LEVELS)) u_tail (
        .i_clk(i_clk), .i_we(tl_we), .i_waddr(tl_wa), .i_wdata(tl_wd),
        .i_re(i_cmd.capture), .i_raddr(LW'(i_task_priority)), .o_rdata(tl_q));
    prq_ram #(.WIDTH(TW), .DEPTH(TASK_SLOTS)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_re(i_cmd.capture), .i_raddr(TW'(i_task_id)), .o_rdata(nx_q));
    prq_ram #(.WIDTH(TW), .DEPTH(TASK_SLOTS)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_re(i_cmd.capture), .i_raddr(TW'(i_task_id)), .o_rdata(pv_q));
    prq_ram #(.WIDTH(LW), .DEPTH(TASK_SLOTS)) u_level (
        .i_clk(i_clk), .i_we(lvl_we), .i_waddr(r_t), .i_wdata(r_p),
        .i_re(i_cmd.capture), .i_raddr(TW'(i_task_id)), .o_rdata(lvl_q));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_ready_valid  <= |r_bitmap;
            o_top_priority <= (|r_bitmap) ? PRIO_W'(best) : '0;
            o_next_task    <= (|r_bitmap) ? TASK_W'(hd_q) : '0;
            o_empty_error  <= r_err;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/priority_ready_queue_unit.sv =====
// top level of the priority ready queue: controller, datapath and channel wiring
//
// channel  | dir | fields
// i_req    | in  | command, task_id, task_priority, active_priority
// o_rsp    | out | ready_valid, top_priority, next_task, empty_error
//
// the result is loaded after the request is accepted, through the look, fetch and
// done steps, with a fix step after look for a move to tail of a task in the middle
// of its list (the next and prev link rams have one write port each, so the unlink
// and the append take separate cycles). the next request is accepted in the cycle
// after the load, so a new request is not taken before the last result is loaded.
// the result sits in an output register until taken; a request that reaches done
// while it is still pending waits there. reset clears the level bitmap and the
// per-task queued flags; the link rams need no clearing.
`default_nettype none
module priority_ready_queue_unit #(
    parameter int PRIORITY_LEVELS = prq_pkg::DEF_PRIORITY_LEVELS,
    parameter int TASK_SLOTS      = prq_pkg::DEF_TASK_SLOTS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    prq_req_if.sink   i_req,
    prq_rsp_if.source o_rsp
);
    import prq_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    prq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_req.valid), .o_in_ready(i_req.ready),
        .o_out_valid(o_rsp.valid), .i_out_ready(o_rsp.ready),
        .i_stat(stat), .o_cmd(cmd));

    prq_datapath #(.PRIORITY_LEVELS(PRIORITY_LEVELS), .TASK_SLOTS(TASK_SLOTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_command(i_req.command), .i_task_id(i_req.task_id),
        .i_task_priority(i_req.task_priority),
        .i_active_priority(i_req.active_priority),
        .o_ready_valid(o_rsp.ready_valid), .o_top_priority(o_rsp.top_priority),
        .o_next_task(o_rsp.next_task), .o_empty_error(o_rsp.empty_error));
endmodule
`default_nettype wire
